/* rtl/core/rgbscl_pkg.sv */
// ----------------------------------------------------------------------------
// rgbscl_pkg
// Shared types and constants of the 5-to-4 RGB555 horizontal scaler.
// ----------------------------------------------------------------------------
package rgbscl_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int CH_W              = 5;
    localparam int NUM_CH            = 3;
    localparam int COLOR_W           = CH_W * NUM_CH;

    typedef logic [2:0]         phase_t;
    typedef logic [COLOR_W-1:0] color_t;

    localparam phase_t PHASE_FIRST = 3'd0;
    localparam phase_t PHASE_LAST  = 3'd4;
    localparam phase_t GROUP_SIZE  = 3'd5;

    localparam logic CMD_PIXEL     = 1'b0;
    localparam logic CMD_PAL_WRITE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pixel;
        logic [7:0]  pal_addr;
        logic [15:0] pal_data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pixel_out;
        logic        group_last;
    } out_item_t;

    typedef struct packed {
        color_t prev;
        color_t cur;
        phase_t phase;
    } job_t;

endpackage

/* rtl/core/rgbscl_front.sv */
// ----------------------------------------------------------------------------
// rgbscl_front
// Item intake: palette store, colour resolution, group phase and previous pixel.
// ----------------------------------------------------------------------------
module rgbscl_front #(
    parameter int PALETTE_DEPTH = rgbscl_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rgbscl_pkg::in_item_t item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    output logic                push,
    output rgbscl_pkg::job_t    push_job,
    input  logic                queue_full
);
    import rgbscl_pkg::*;

    localparam int         AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    logic [15:0] palette_mem [PALETTE_DEPTH];
    logic [15:0] rd_data_reg;

    logic   indexed_mode_reg;
    logic   f1_valid_reg, f1_valid_next;
    color_t f1_direct_reg;
    logic   f1_oob_reg;
    phase_t phase_reg, phase_next;
    color_t prev_reg, prev_next;

    logic   accept;
    logic   pix_accept;
    logic   wr_accept;
    logic   f1_advance;
    color_t color;

    assign cfg_ready  = 1'b1;
    assign item_stall = f1_valid_reg && queue_full;
    assign accept     = item_valid && !item_stall;
    assign pix_accept = accept && (item.cmd == CMD_PIXEL);
    assign wr_accept  = accept && (item.cmd == CMD_PAL_WRITE)
                        && ({1'b0, item.pal_addr} < DEPTH_LIM);
    assign f1_advance = f1_valid_reg && !queue_full;

    always_ff @(posedge clk)
    begin
        if (wr_accept)
        begin
            palette_mem[item.pal_addr[AW-1:0]] <= item.pal_data;
        end
        if (pix_accept)
        begin
            rd_data_reg   <= palette_mem[item.pixel[AW-1:0]];
            f1_direct_reg <= item.pixel[COLOR_W-1:0];
            f1_oob_reg    <= ({1'b0, item.pixel[7:0]} >= DEPTH_LIM);
        end
    end

    always_comb
    begin
        if (indexed_mode_reg)
        begin
            color = f1_oob_reg ? '0 : rd_data_reg[COLOR_W-1:0];
        end
        else
        begin
            color = f1_direct_reg;
        end
    end

    always_comb
    begin
        f1_valid_next = f1_valid_reg;
        phase_next    = phase_reg;
        prev_next     = prev_reg;
        if (f1_advance)
        begin
            f1_valid_next = 1'b0;
            phase_next    = (phase_reg == PHASE_LAST) ? PHASE_FIRST : phase_reg + 3'd1;
            prev_next     = color;
        end
        if (pix_accept)
        begin
            f1_valid_next = 1'b1;
        end
    end

    assign push     = f1_advance && (phase_reg != PHASE_FIRST);
    assign push_job = '{prev: prev_reg, cur: color, phase: phase_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            indexed_mode_reg <= 1'b0;
            f1_valid_reg     <= 1'b0;
            phase_reg        <= PHASE_FIRST;
            prev_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                indexed_mode_reg <= cfg_data;
            end
            f1_valid_reg <= f1_valid_next;
            phase_reg    <= phase_next;
            prev_reg     <= prev_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("group phase out of range");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (f1_valid_reg && queue_full) |=> (f1_valid_reg && $stable(phase_reg)))
        else $error("pending pixel lost while queue full");
`endif

endmodule

/* rtl/core/rgbscl_queue.sv */
// ----------------------------------------------------------------------------
// rgbscl_queue
// Short job queue between intake and blend pipeline.
// ----------------------------------------------------------------------------
module rgbscl_queue #(
    parameter int DEPTH = rgbscl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rgbscl_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output rgbscl_pkg::job_t pop_job
);
    import rgbscl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t            q_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full      = (count_reg == (PW+1)'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !pop_valid))
        else $error("pop from empty queue");
`endif

endmodule

/* rtl/core/rgbscl_back.sv */
// ----------------------------------------------------------------------------
// rgbscl_back
// Blend pipeline: weighted channel sums, rounded division by five, output register.
// ----------------------------------------------------------------------------
module rgbscl_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    input  rgbscl_pkg::job_t      pop_job,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rgbscl_pkg::out_item_t result
);
    import rgbscl_pkg::*;

    localparam int SUM_W       = 8;
    localparam int PROD_W      = 22;
    localparam int RECIP_10    = 6554;
    localparam int RECIP_SHIFT = 16;
    localparam int ROUND_BIAS  = 5;

    function automatic logic [SUM_W-1:0] blend_sum(input logic [CH_W-1:0] a,
                                                   input phase_t wa,
                                                   input logic [CH_W-1:0] b,
                                                   input phase_t wb);
        return SUM_W'(a) * SUM_W'(wa) + SUM_W'(b) * SUM_W'(wb);
    endfunction

    function automatic logic [CH_W-1:0] div10_round(input logic [SUM_W-1:0] s);
        logic [SUM_W:0]    x;
        logic [PROD_W-1:0] p;
        x = {s, 1'b0} + (SUM_W+1)'(ROUND_BIAS);
        p = PROD_W'(x) * PROD_W'(RECIP_10);
        return p[RECIP_SHIFT +: CH_W];
    endfunction

    logic             a_valid_reg;
    logic [SUM_W-1:0] a_sum_reg [NUM_CH];
    logic             a_last_reg;
    logic             b_valid_reg;
    logic [15:0]      b_pixel_reg;
    logic             b_last_reg;

    logic             a_free, b_free, a_move;
    phase_t           w_prev;
    logic [SUM_W-1:0] sum_next [NUM_CH];
    color_t           blended;

    assign b_free = !b_valid_reg || !result_stall;
    assign a_free = !a_valid_reg || b_free;
    assign pop    = pop_valid && a_free;
    assign a_move = a_valid_reg && b_free;
    assign w_prev = GROUP_SIZE - pop_job.phase;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_next[c] = blend_sum(pop_job.prev[c*CH_W +: CH_W], w_prev,
                                    pop_job.cur[c*CH_W +: CH_W], pop_job.phase);
            blended[c*CH_W +: CH_W] = div10_round(a_sum_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_sum_reg  <= sum_next;
            a_last_reg <= (pop_job.phase == PHASE_LAST);
        end
        if (a_move)
        begin
            b_pixel_reg <= {1'b1, blended};
            b_last_reg  <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= pop;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    assign result_valid = b_valid_reg;
    assign result       = '{pixel_out: b_pixel_reg, group_last: b_last_reg};

`ifndef SYNTHESIS
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> (a_valid_reg && $stable(a_last_reg)))
        else $error("blend stage dropped a job under stall");

    a_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && a_free) |=> a_valid_reg)
        else $error("popped job not captured");
`endif

endmodule

/* rtl/core/rgb1555_five_to_four_scaler.sv */
// ----------------------------------------------------------------------------
// rgb1555_five_to_four_scaler
// Horizontal 5-to-4 downscaler for RGB555 pixels with optional palette.
// ----------------------------------------------------------------------------
// Usage
//   item channel (item_valid / item_stall / item): a pixel or a palette write
//   each transfer; one item per clock is taken while nothing downstream stalls.
//   result channel (result_valid / result_stall / result): four blended pixels
//   per five input pixels, group_last marking the fourth of each group.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): indexed_mode, always ready;
//   write it only while the block is idle.
// Path: a pixel passes the palette read register, the job queue (QUEUE_DEPTH
//   entries, four by default), the sum stage and the rounded output register.
// Throughput: one item per clock while item_stall is low.
// Reset clears the group phase, the previous pixel and indexed_mode; palette
//   contents stay undefined until written.
// When the receiver stalls the result register holds, the queue fills, and
//   item_stall rises only once the queue is full and a pixel is pending.
// ----------------------------------------------------------------------------
module rgb1555_five_to_four_scaler #(
    parameter int PALETTE_DEPTH = rgbscl_pkg::PALETTE_DEPTH_DEF,
    parameter int QUEUE_DEPTH   = rgbscl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  rgbscl_pkg::in_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rgbscl_pkg::out_item_t result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import rgbscl_pkg::*;

    logic push, full, pop, pop_valid;
    job_t push_job, pop_job;

    rgbscl_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .push_job   (push_job),
        .queue_full (full)
    );

    rgbscl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_job   (pop_job)
    );

    rgbscl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_job      (pop_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
